// ===== rtl/ame_pkg.sv =====
// ----------------------------------------------------------------------------
// ame_pkg
// Types and codes shared by the accumulator machine execute block.
// ----------------------------------------------------------------------------
package ame_pkg;

	// Action codes of a decoded instruction
	localparam logic [3:0] ACT_NOP     = 4'd0;
	localparam logic [3:0] ACT_STA     = 4'd1;
	localparam logic [3:0] ACT_LDA     = 4'd2;
	localparam logic [3:0] ACT_ADD     = 4'd3;
	localparam logic [3:0] ACT_OR      = 4'd4;
	localparam logic [3:0] ACT_AND     = 4'd5;
	localparam logic [3:0] ACT_NOT     = 4'd6;
	localparam logic [3:0] ACT_JMP     = 4'd7;
	localparam logic [3:0] ACT_JN      = 4'd8;
	localparam logic [3:0] ACT_JZ      = 4'd9;
	localparam logic [3:0] ACT_JNZ     = 4'd10;
	localparam logic [3:0] ACT_HLT     = 4'd11;
	localparam logic [3:0] ACT_PRELOAD = 4'd12;

	// Sign bit position of the accumulator
	localparam int SIGN_POS = 7;

	// Instruction as it arrives
	typedef struct packed {
		logic [3:0] action;
		logic [7:0] address;
		logic [7:0] load_value;
	} in_t;

	// Result of one instruction
	typedef struct packed {
		logic [7:0] accumulator;
		logic [7:0] program_counter;
		logic       negative;
		logic       zero;
		logic       halted;
	} res_t;

	// Classified instruction handed from front to back
	typedef struct packed {
		logic [3:0] action;
		logic [7:0] address;
		logic [7:0] load_value;
		logic [7:0] mem_index;  // address folded into the memory range
		logic       mem_write;  // store or preload
	} op_t;

endpackage

// ===== rtl/ame_fifo.sv =====
// ----------------------------------------------------------------------------
// ame_fifo
// Small register queue with push/pop handshake, used between the parts.
// ----------------------------------------------------------------------------
module ame_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == FULL_CNT);
	assign rd_data = slot_q[rd_ptr_q];
	assign do_wr   = wr_en;
	assign do_rd   = rd_en && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ame_front.sv =====
// ----------------------------------------------------------------------------
// ame_front
// Accepts instructions, folds the address into the memory range and marks
// memory writes before handing them to the op queue.
// ----------------------------------------------------------------------------
module ame_front #(
	parameter int MEM_DEPTH = 256
) (
	input  logic          push,
	input  ame_pkg::in_t  request,
	output logic          full,
	input  logic          op_full,
	output logic          op_wr,
	output ame_pkg::op_t  op_data
);

	localparam logic [11:0] DEPTH_W = 12'(MEM_DEPTH);

	logic [11:0] rem;

	// address modulo depth: four restoring steps, exact while the quotient is below 16 (MEM_DEPTH of 16 or more)
	always_comb begin
		rem = {4'b0, request.address};
		for (int k = 3; k >= 0; k--) begin
			if (rem >= (DEPTH_W << k)) begin
				rem = rem - (DEPTH_W << k);
			end
		end
	end

	assign full  = op_full;
	assign op_wr = push && !op_full;

	// classify
	always_comb begin
		op_data.action     = request.action;
		op_data.address    = request.address;
		op_data.load_value = request.load_value;
		op_data.mem_index  = rem[7:0];
		op_data.mem_write  = (request.action == ame_pkg::ACT_STA) ||
		                     (request.action == ame_pkg::ACT_PRELOAD);
	end

endmodule

// ===== rtl/ame_back.sv =====
// ----------------------------------------------------------------------------
// ame_back
// Execute part: data memory read in one stage, execution and write-back in
// the next, with forwarding of the byte written in the same cycle.
// ----------------------------------------------------------------------------
module ame_back #(
	parameter int MEM_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_empty,
	input  ame_pkg::op_t  op_data,
	output logic          op_rd,
	input  logic          res_room,
	output logic          res_wr,
	output ame_pkg::res_t res_data
);

	localparam int IDX_W = $clog2(MEM_DEPTH);

	// data memory with per-entry valid bits (cleared entries read as zero)
	logic [7:0]           mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] mem_vld_q;

	// architectural state
	logic [7:0] acc_q;
	logic [7:0] pc_q;

	// stage one: op under execution and its operand read
	ame_pkg::op_t op_s1;
	logic         vld_s1;
	logic [7:0]   rd_mem_s1;
	logic         rd_vld_s1;
	logic         fwd_s1;
	logic [7:0]   fwd_data_s1;

	logic             exec;
	logic             load_s1;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;
	logic             wr_en;
	logic [7:0]       wr_data;
	logic [7:0]       operand;
	logic [7:0]       pc_inc1;
	logic [7:0]       pc_inc2;
	logic [7:0]       acc_n;
	logic [7:0]       pc_n;
	logic             halt_n;

	assign exec    = vld_s1 && res_room;
	assign load_s1 = !vld_s1 || exec;
	assign op_rd   = load_s1 && !op_empty;
	assign rd_idx  = op_data.mem_index[IDX_W-1:0];
	assign wr_idx  = op_s1.mem_index[IDX_W-1:0];
	assign wr_en   = exec && op_s1.mem_write;
	assign wr_data = (op_s1.action == ame_pkg::ACT_STA) ? acc_q : op_s1.load_value;

	// operand: forwarded byte, else stored byte, else cleared value
	assign operand = fwd_s1 ? fwd_data_s1 : (rd_vld_s1 ? rd_mem_s1 : 8'd0);
	assign pc_inc1 = pc_q + 8'd1;
	assign pc_inc2 = pc_q + 8'd2;

	// execute
	always_comb begin
		acc_n  = acc_q;
		pc_n   = pc_q;
		halt_n = 1'b0;
		unique case (op_s1.action)
			ame_pkg::ACT_NOP: pc_n = pc_inc1;
			ame_pkg::ACT_STA: pc_n = pc_inc2;
			ame_pkg::ACT_LDA: begin
				acc_n = operand;
				pc_n  = pc_inc2;
			end
			ame_pkg::ACT_ADD: begin
				acc_n = acc_q + operand;
				pc_n  = pc_inc2;
			end
			ame_pkg::ACT_OR: begin
				acc_n = acc_q | operand;
				pc_n  = pc_inc2;
			end
			ame_pkg::ACT_AND: begin
				acc_n = acc_q & operand;
				pc_n  = pc_inc2;
			end
			ame_pkg::ACT_NOT: begin
				acc_n = ~acc_q;
				pc_n  = pc_inc1;
			end
			ame_pkg::ACT_JMP: pc_n = op_s1.address;
			ame_pkg::ACT_JN:  pc_n = acc_q[ame_pkg::SIGN_POS] ? op_s1.address : pc_inc2;
			ame_pkg::ACT_JZ:  pc_n = (acc_q == 8'd0) ? op_s1.address : pc_inc2;
			ame_pkg::ACT_JNZ: pc_n = (acc_q != 8'd0) ? op_s1.address : pc_inc2;
			ame_pkg::ACT_HLT: halt_n = 1'b1;
			ame_pkg::ACT_PRELOAD: ;
			default: ;
		endcase
	end

	assign res_wr                   = exec;
	assign res_data.accumulator     = acc_n;
	assign res_data.program_counter = pc_n;
	assign res_data.negative        = acc_n[ame_pkg::SIGN_POS];
	assign res_data.zero            = (acc_n == 8'd0);
	assign res_data.halted          = halt_n;

	// memory array and stage-one payload
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (op_rd) begin
			op_s1       <= op_data;
			rd_mem_s1   <= mem_q[rd_idx];
			fwd_data_s1 <= wr_data;
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= '0;
			acc_q     <= 8'd0;
			pc_q      <= 8'd0;
			vld_s1    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (wr_en) begin
				mem_vld_q[wr_idx] <= 1'b1;
			end
			if (exec) begin
				acc_q <= acc_n;
				pc_q  <= pc_n;
			end
			if (load_s1) begin
				vld_s1 <= op_rd;
			end
			if (op_rd) begin
				rd_vld_s1 <= mem_vld_q[rd_idx];
				fwd_s1    <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

endmodule

// ===== rtl/accumulator_machine_execute.sv =====
// ----------------------------------------------------------------------------
// accumulator_machine_execute
// Eight-bit accumulator machine execute block with data memory.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------
//   input    | push / full      | request : action, address, load_value
//   result   | pop / empty      | result  : acc, pc, negative, zero, halted
//
// One instruction per cycle sustained while the result side has room; a push
// reaches a result through the op queue, the memory read stage into execute
// and the result queue. The single memory read port and the execute loop on
// the accumulator and pc set that rate; store data is forwarded to a read of the
// same entry. Reset clears the memory valid bits at once, so no sweep is run.
// A stalled result side backs up through a two-entry result queue, the
// execute stage and a two-entry op queue before full rises.
// ----------------------------------------------------------------------------
module accumulator_machine_execute #(
	parameter int MEM_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  ame_pkg::in_t  request,
	output logic          empty,
	input  logic          pop,
	output ame_pkg::res_t result
);

	localparam int Q_DEPTH = 2;
	localparam int OP_W    = $bits(ame_pkg::op_t);
	localparam int RES_W   = $bits(ame_pkg::res_t);

	logic         op_full;
	logic         op_empty;
	logic         op_wr;
	logic         op_rd;
	ame_pkg::op_t op_in;
	ame_pkg::op_t op_out;
	logic         res_full;
	logic         res_room;
	logic         res_wr;
	ame_pkg::res_t res_in;

	// front: accept and classify
	ame_front #(.MEM_DEPTH(MEM_DEPTH)) u_front (
		.push    (push),
		.request (request),
		.full    (full),
		.op_full (op_full),
		.op_wr   (op_wr),
		.op_data (op_in)
	);

	// op queue between front and back
	ame_fifo #(.WIDTH(OP_W), .DEPTH(Q_DEPTH)) u_op_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_wr),
		.wr_data (op_in),
		.full    (op_full),
		.rd_en   (op_rd),
		.rd_data (op_out),
		.empty   (op_empty)
	);

	// back: execute
	ame_back #(.MEM_DEPTH(MEM_DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (op_empty),
		.op_data  (op_out),
		.op_rd    (op_rd),
		.res_room (res_room),
		.res_wr   (res_wr),
		.res_data (res_in)
	);

	// room for a result when not full or when one leaves this cycle
	assign res_room = !res_full || (pop && !empty);

	// result queue
	ame_fifo #(.WIDTH(RES_W), .DEPTH(Q_DEPTH)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
